/* rtl/core/sshs_pkg.sv */
// Shared types, constants and the CRC-32 byte step for the sector header scanner.
// No dependencies.
package sshs_pkg;

    localparam int SECTORS_PER_BLOCK_DEF = 8;
    localparam int HEADER_BYTES          = 32;
    localparam int CRC_SPAN              = 28;
    localparam int BYTE_POS_W            = 5;

    localparam logic [BYTE_POS_W-1:0] POS_START_MAGIC = BYTE_POS_W'(3);
    localparam logic [BYTE_POS_W-1:0] POS_SERIAL      = BYTE_POS_W'(7);
    localparam logic [BYTE_POS_W-1:0] POS_END_MAGIC   = BYTE_POS_W'(CRC_SPAN - 1);
    localparam logic [BYTE_POS_W-1:0] POS_LAST        = BYTE_POS_W'(HEADER_BYTES - 1);
    localparam logic [BYTE_POS_W-1:0] POS_CRC_END     = BYTE_POS_W'(CRC_SPAN);

    localparam logic [31:0] MAGIC_START = 32'h434F_4F4C;
    localparam logic [31:0] MAGIC_END   = 32'h4845_5244;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CLASS_UNINIT  = 2'd0,
        CLASS_CORRUPT = 2'd1,
        CLASS_EMPTY   = 2'd2,
        CLASS_SAVED   = 2'd3
    } class_t;

    // Reflected CRC-32 over one byte; the bit loop folds into an XOR network.
    function automatic logic [31:0] crc_step(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/save_sector_header_scan_top.sv */
// Save-block sector header scanner: top level, one byte per beat in, one result per sector.
// Depends on sshs_pkg.
//
// Takes one header byte per cycle, with no gaps unless a stalled result holds back a
// sector's last byte: the byte is registered, checked by one pass of CRC, magic and
// serial logic, and the sector result lands in an output register. A result beat is
// registered from the last (32nd) byte of each sector. A stalled result stalls the input
// only when a new result is ready to replace it. scan_start on a byte drops any
// partial sector or block and takes that byte as byte 0 of sector 0; after the
// last sector of a block the scan state clears by itself.
module save_sector_header_scan_top
    import sshs_pkg::*;
#(
    parameter int SECTORS_PER_BLOCK = SECTORS_PER_BLOCK_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_read_failed,
    input  logic        s_scan_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_sector_index,
    output logic [1:0]  m_sector_class,
    output logic [30:0] m_sector_serial,
    output logic        m_block_done,
    output logic [1:0]  m_block_status,
    output logic [2:0]  m_newest_sector,
    output logic [30:0] m_newest_serial
);

    localparam int SEC_W = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTORS_PER_BLOCK - 1);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_fail_reg;
    logic       in_start_reg;

    // scan state
    logic [BYTE_POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [SEC_W-1:0]      sector_pos_reg, sector_pos_next;
    logic [31:0]           crc_reg, crc_next;
    logic [31:0]           word_reg, word_next;
    logic                  smagic_reg, smagic_next;
    logic                  emagic_reg, emagic_next;
    logic [31:0]           serial_reg, serial_next;
    logic                  rbad_reg, rbad_next;
    class_t                bstate_reg, bstate_next;
    logic [30:0]           best_serial_reg, best_serial_next;
    logic                  best_valid_reg, best_valid_next;
    logic [SEC_W-1:0]      best_sector_reg, best_sector_next;
    logic                  uninit_reg, uninit_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_index_reg, out_index_next;
    class_t      out_class_reg, out_class_next;
    logic [30:0] out_serial_reg, out_serial_next;
    logic        out_done_reg, out_done_next;
    class_t      out_status_reg, out_status_next;
    logic [2:0]  out_nsec_reg, out_nsec_next;
    logic [30:0] out_nser_reg, out_nser_next;

    logic go;
    logic last;
    logic done;
    class_t cls;
    class_t status;
    logic [30:0] serial31;

    // working copies after the optional block clear
    logic [BYTE_POS_W-1:0] bp;
    logic [SEC_W-1:0]      sp;
    logic [31:0]           crc, word, serial;
    logic                  smagic, emagic, rbad, bval, uninit;
    class_t                bstate;
    logic [30:0]           bser;
    logic [SEC_W-1:0]      bsec;

    // only the last byte of a sector needs room in the result register
    assign go      = in_valid_reg && (!last || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || go;

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
    end

    always_comb begin
        bp     = in_start_reg ? '0 : byte_pos_reg;
        sp     = in_start_reg ? '0 : sector_pos_reg;
        crc    = in_start_reg ? CRC_ONES : crc_reg;
        word   = in_start_reg ? '0 : word_reg;
        smagic = in_start_reg ? 1'b0 : smagic_reg;
        emagic = in_start_reg ? 1'b0 : emagic_reg;
        serial = in_start_reg ? '0 : serial_reg;
        rbad   = (in_start_reg ? 1'b0 : rbad_reg) | in_fail_reg;
        bstate = in_start_reg ? CLASS_UNINIT : bstate_reg;
        bser   = in_start_reg ? '0 : best_serial_reg;
        bval   = in_start_reg ? 1'b0 : best_valid_reg;
        bsec   = in_start_reg ? '0 : best_sector_reg;
        uninit = in_start_reg ? 1'b0 : uninit_reg;

        if (bp < POS_CRC_END) begin
            crc = crc_step(crc, in_byte_reg);
        end
        word = {in_byte_reg, word[31:8]};
        if (bp == POS_START_MAGIC) begin
            smagic = (word == MAGIC_START);
        end
        if (bp == POS_SERIAL) begin
            serial = word;
        end
        if (bp == POS_END_MAGIC) begin
            emagic = (word == MAGIC_END);
        end

        last     = (bp == POS_LAST);
        done     = (sp == SEC_LAST);
        serial31 = serial[30:0];

        // precedence: read fault, no magic, one magic, CRC, top serial bit
        if (rbad) begin
            cls = CLASS_CORRUPT;
        end else if (!smagic && !emagic) begin
            cls = CLASS_UNINIT;
        end else if (!smagic || !emagic) begin
            cls = CLASS_CORRUPT;
        end else if (word != (crc ^ CRC_ONES)) begin
            cls = CLASS_CORRUPT;
        end else if (serial[31]) begin
            cls = CLASS_CORRUPT;
        end else if (serial == '0) begin
            cls = CLASS_EMPTY;
        end else begin
            cls = CLASS_SAVED;
        end

        // block tracking; frozen once corrupt
        if (last && bstate != CLASS_CORRUPT) begin
            if (cls == CLASS_CORRUPT) begin
                bstate = CLASS_CORRUPT;
            end else if (cls == CLASS_UNINIT) begin
                uninit = 1'b1;
            end else if (!bval || serial31 > bser) begin
                bval   = 1'b1;
                bser   = serial31;
                bsec   = sp;
                bstate = (serial31 != '0) ? CLASS_SAVED : CLASS_EMPTY;
            end
        end

        status = bstate;
        if (status != CLASS_CORRUPT && uninit && status != CLASS_UNINIT) begin
            status = CLASS_CORRUPT;
        end
    end

    always_comb begin
        byte_pos_next    = byte_pos_reg;
        sector_pos_next  = sector_pos_reg;
        crc_next         = crc_reg;
        word_next        = word_reg;
        smagic_next      = smagic_reg;
        emagic_next      = emagic_reg;
        serial_next      = serial_reg;
        rbad_next        = rbad_reg;
        bstate_next      = bstate_reg;
        best_serial_next = best_serial_reg;
        best_valid_next  = best_valid_reg;
        best_sector_next = best_sector_reg;
        uninit_next      = uninit_reg;

        out_valid_next  = out_valid_reg && !m_ready;
        out_index_next  = out_index_reg;
        out_class_next  = out_class_reg;
        out_serial_next = out_serial_reg;
        out_done_next   = out_done_reg;
        out_status_next = out_status_reg;
        out_nsec_next   = out_nsec_reg;
        out_nser_next   = out_nser_reg;

        if (go) begin
            if (!last) begin
                byte_pos_next    = bp + BYTE_POS_W'(1);
                sector_pos_next  = sp;
                crc_next         = crc;
                word_next        = word;
                smagic_next      = smagic;
                emagic_next      = emagic;
                serial_next      = serial;
                rbad_next        = rbad;
                bstate_next      = bstate;
                best_serial_next = bser;
                best_valid_next  = bval;
                best_sector_next = bsec;
                uninit_next      = uninit;
            end else begin
                out_valid_next  = 1'b1;
                out_index_next  = 3'(sp);
                out_class_next  = cls;
                out_serial_next = serial31;
                out_done_next   = done;
                out_status_next = done ? status : CLASS_UNINIT;
                out_nsec_next   = (done && status == CLASS_SAVED) ? 3'(bsec) : 3'd0;
                out_nser_next   = (done && bval) ? bser : 31'd0;

                // clear the sector; at the block's end clear the block too
                byte_pos_next = '0;
                crc_next      = CRC_ONES;
                word_next     = '0;
                smagic_next   = 1'b0;
                emagic_next   = 1'b0;
                serial_next   = '0;
                rbad_next     = 1'b0;
                if (done) begin
                    sector_pos_next  = '0;
                    bstate_next      = CLASS_UNINIT;
                    best_serial_next = '0;
                    best_valid_next  = 1'b0;
                    best_sector_next = '0;
                    uninit_next      = 1'b0;
                end else begin
                    sector_pos_next  = sp + SEC_W'(1);
                    bstate_next      = bstate;
                    best_serial_next = bser;
                    best_valid_next  = bval;
                    best_sector_next = bsec;
                    uninit_next      = uninit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            byte_pos_reg    <= '0;
            sector_pos_reg  <= '0;
            crc_reg         <= CRC_ONES;
            word_reg        <= '0;
            smagic_reg      <= 1'b0;
            emagic_reg      <= 1'b0;
            serial_reg      <= '0;
            rbad_reg        <= 1'b0;
            bstate_reg      <= CLASS_UNINIT;
            best_serial_reg <= '0;
            best_valid_reg  <= 1'b0;
            best_sector_reg <= '0;
            uninit_reg      <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            byte_pos_reg    <= byte_pos_next;
            sector_pos_reg  <= sector_pos_next;
            crc_reg         <= crc_next;
            word_reg        <= word_next;
            smagic_reg      <= smagic_next;
            emagic_reg      <= emagic_next;
            serial_reg      <= serial_next;
            rbad_reg        <= rbad_next;
            bstate_reg      <= bstate_next;
            best_serial_reg <= best_serial_next;
            best_valid_reg  <= best_valid_next;
            best_sector_reg <= best_sector_next;
            uninit_reg      <= uninit_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_fail_reg  <= s_read_failed;
            in_start_reg <= s_scan_start;
        end
        out_index_reg  <= out_index_next;
        out_class_reg  <= out_class_next;
        out_serial_reg <= out_serial_next;
        out_done_reg   <= out_done_next;
        out_status_reg <= out_status_next;
        out_nsec_reg   <= out_nsec_next;
        out_nser_reg   <= out_nser_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_sector_index  = out_index_reg;
    assign m_sector_class  = out_class_reg;
    assign m_sector_serial = out_serial_reg;
    assign m_block_done    = out_done_reg;
    assign m_block_status  = out_status_reg;
    assign m_newest_sector = out_nsec_reg;
    assign m_newest_serial = out_nser_reg;

endmodule

/* rtl/core/sshs_checker.sv */
// Port-level checks for the sector header scanner, bound to the top level.
// Depends on sshs_pkg and save_sector_header_scan_top.
module sshs_checker
    import sshs_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_data_byte,
    input logic        s_read_failed,
    input logic        s_scan_start,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_sector_index,
    input logic [1:0]  m_sector_class,
    input logic [30:0] m_sector_serial,
    input logic        m_block_done,
    input logic [1:0]  m_block_status,
    input logic [2:0]  m_newest_sector,
    input logic [30:0] m_newest_serial
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sector_index)
            && $stable(m_sector_class) && $stable(m_sector_serial)
            && $stable(m_block_done) && $stable(m_newest_serial))
        else $error("result beat changed while stalled");

    a_block_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_block_done |-> m_block_status == CLASS_UNINIT
            && m_newest_sector == 3'd0 && m_newest_serial == 31'd0)
        else $error("block fields set before the block's last sector");

    a_newest_only_saved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_status != CLASS_SAVED |-> m_newest_sector == 3'd0)
        else $error("newest sector reported without a save");

    a_corrupt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_done && m_sector_class == CLASS_CORRUPT
            |-> m_block_status == CLASS_CORRUPT)
        else $error("corrupt last sector left block not corrupt");

endmodule

bind save_sector_header_scan_top sshs_checker u_sshs_checker (.*);

/* tb/sv/save_sector_header_scan_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for save_sector_header_scan_top: streams sector header bytes, predicts each
// sector and block report with a local scanner model and checks every result beat.
// Depends on sshs_pkg and the scanner RTL.
module save_sector_header_scan_top_tb;
    import sshs_pkg::*;

    localparam int SECTORS      = SECTORS_PER_BLOCK_DEF;
    localparam int BLOCK_BYTES  = SECTORS * HEADER_BYTES;
    localparam int RANDOM_BYTES = 256;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 10;

    // Header shapes the generator can build
    typedef enum int {
        HDR_VALID, HDR_BLANK, HDR_GARBAGE, HDR_NO_START,
        HDR_NO_END, HDR_BAD_CRC, HDR_TOP_BIT, HDR_READ_FAIL
    } hdr_kind_t;

    typedef struct packed {
        logic [2:0]  idx;
        class_t      cls;
        logic [30:0] serial;
        logic        done;
        class_t      status;
        logic [2:0]  newest_idx;
        logic [30:0] newest_serial;
    } sector_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_read_failed = 1'b0;
    logic        s_scan_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_sector_index;
    logic [1:0]  m_sector_class;
    logic [30:0] m_sector_serial;
    logic        m_block_done;
    logic [1:0]  m_block_status;
    logic [2:0]  m_newest_sector;
    logic [30:0] m_newest_serial;

    logic steady = 1'b0;
    int   errors = 0;
    int   bytes_sent = 0;
    int   reports_predicted = 0;
    int   reports_checked = 0;
    int   block_status_count [4] = '{0, 0, 0, 0};

    // Scanner model state
    logic [4:0]  hdr_pos;
    logic [2:0]  sect_num;
    logic [31:0] crc_run;
    logic [31:0] word_win;
    logic [31:0] serial_word;
    logic        start_ok;
    logic        end_ok;
    logic        sect_read_err;
    class_t      blk_state;
    logic [30:0] top_serial;
    logic        top_valid;
    logic [2:0]  top_sector;
    logic        any_blank;
    sector_report_t sector_reports [$];

    // Generator scratch
    logic [7:0]  hdr_bytes [HEADER_BYTES];
    int          fail_byte;
    hdr_kind_t   blk_kind [SECTORS];
    logic [31:0] blk_serial [SECTORS];

    save_sector_header_scan_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_read_failed   (s_read_failed),
        .s_scan_start    (s_scan_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sector_index  (m_sector_index),
        .m_sector_class  (m_sector_class),
        .m_sector_serial (m_sector_serial),
        .m_block_done    (m_block_done),
        .m_block_status  (m_block_status),
        .m_newest_sector (m_newest_sector),
        .m_newest_serial (m_newest_serial)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Bitwise reflected CRC-32: feed one data bit into the feedback per shift
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] r;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0] ^ d[i]}});
        end
        return r;
    endfunction

    function automatic void clear_sector_state();
        hdr_pos       = '0;
        crc_run       = CRC_ONES;
        word_win      = '0;
        serial_word   = '0;
        start_ok      = 1'b0;
        end_ok        = 1'b0;
        sect_read_err = 1'b0;
    endfunction

    function automatic void clear_block_state();
        clear_sector_state();
        sect_num   = '0;
        blk_state  = CLASS_UNINIT;
        top_serial = '0;
        top_valid  = 1'b0;
        top_sector = '0;
        any_blank  = 1'b0;
    endfunction

    // Advance the scanner model by one accepted byte; queue a report on the last header byte
    function automatic void predict_byte(input logic [7:0] d, input logic rf, input logic ss);
        sector_report_t rep;
        class_t         cls;
        class_t         status;
        logic [30:0]    ser31;
        logic           last_sect;
        if (ss)
            clear_block_state();
        if (rf)
            sect_read_err = 1'b1;
        if (hdr_pos < POS_CRC_END)
            crc_run = crc32_update(crc_run, d);
        word_win = {d, word_win[31:8]};
        if (hdr_pos == POS_START_MAGIC)
            start_ok = (word_win == MAGIC_START);
        if (hdr_pos == POS_SERIAL)
            serial_word = word_win;
        if (hdr_pos == POS_END_MAGIC)
            end_ok = (word_win == MAGIC_END);
        if (hdr_pos != POS_LAST) begin
            hdr_pos++;
            return;
        end

        // word_win now holds the stored CRC
        if (sect_read_err)
            cls = CLASS_CORRUPT;
        else if (!start_ok && !end_ok)
            cls = CLASS_UNINIT;
        else if (!start_ok || !end_ok)
            cls = CLASS_CORRUPT;
        else if (word_win != ~crc_run)
            cls = CLASS_CORRUPT;
        else if (serial_word[31])
            cls = CLASS_CORRUPT;
        else if (serial_word == 32'd0)
            cls = CLASS_EMPTY;
        else
            cls = CLASS_SAVED;
        ser31 = serial_word[30:0];

        // A corrupt block freezes the newest-sector tracking
        if (blk_state != CLASS_CORRUPT) begin
            if (cls == CLASS_CORRUPT) begin
                blk_state = CLASS_CORRUPT;
            end else if (cls == CLASS_UNINIT) begin
                any_blank = 1'b1;
            end else if (!top_valid || ser31 > top_serial) begin
                top_valid  = 1'b1;
                top_serial = ser31;
                top_sector = sect_num;
                blk_state  = (ser31 != 31'd0) ? CLASS_SAVED : CLASS_EMPTY;
            end
        end

        last_sect = (sect_num == SECTORS - 1);
        status = blk_state;
        if (status != CLASS_CORRUPT && status != CLASS_UNINIT && any_blank)
            status = CLASS_CORRUPT;

        rep.idx           = sect_num;
        rep.cls           = cls;
        rep.serial        = ser31;
        rep.done          = last_sect;
        rep.status        = last_sect ? status : CLASS_UNINIT;
        rep.newest_idx    = (last_sect && status == CLASS_SAVED) ? top_sector : 3'd0;
        rep.newest_serial = (last_sect && top_valid) ? top_serial : 31'd0;
        sector_reports.push_back(rep);
        reports_predicted++;

        if (last_sect) begin
            block_status_count[status]++;
            clear_block_state();
        end else begin
            sect_num++;
            clear_sector_state();
        end
    endfunction

    function automatic logic [7:0] bit_flip();
        return 8'(1 << $urandom_range(0, 7));
    endfunction

    function automatic void build_header(input hdr_kind_t kind, input logic [31:0] serial);
        logic [31:0] crc;
        logic [31:0] ser;
        int          k;
        fail_byte = -1;
        for (int i = 0; i < HEADER_BYTES; i++)
            hdr_bytes[i] = 8'($urandom_range(0, 255));
        if (kind == HDR_GARBAGE)
            return;
        if (kind == HDR_BLANK) begin
            for (int i = 0; i < HEADER_BYTES; i++)
                hdr_bytes[i] = 8'hFF;
            return;
        end
        ser = (kind == HDR_TOP_BIT) ? (serial | 32'h8000_0000) : serial;
        for (int i = 0; i < 4; i++) begin
            hdr_bytes[i]      = MAGIC_START[8*i +: 8];
            hdr_bytes[4 + i]  = ser[8*i +: 8];
            hdr_bytes[24 + i] = MAGIC_END[8*i +: 8];
        end
        if (kind == HDR_NO_START) begin
            k = $urandom_range(0, 3);
            hdr_bytes[k] ^= bit_flip();
        end
        if (kind == HDR_NO_END) begin
            k = $urandom_range(24, 27);
            hdr_bytes[k] ^= bit_flip();
        end
        crc = CRC_ONES;
        for (int i = 0; i < CRC_SPAN; i++)
            crc = crc32_update(crc, hdr_bytes[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++)
            hdr_bytes[CRC_SPAN + i] = crc[8*i +: 8];
        if (kind == HDR_BAD_CRC) begin
            k = $urandom_range(0, HEADER_BYTES - 1);
            hdr_bytes[k] ^= bit_flip();
        end
        if (kind == HDR_READ_FAIL)
            fail_byte = $urandom_range(0, HEADER_BYTES - 1);
    endfunction

    // Often small serials so that ties happen, plus the extremes and full-range values
    function automatic logic [31:0] pick_serial();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'($urandom_range(0, 7));
        else if (r == 4)
            return 32'd0;
        else if (r == 5)
            return 32'h7FFF_FFFF;
        else if (r == 6)
            return $urandom();
        return {1'b0, 31'($urandom())};
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic rf, input logic ss);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= d;
        s_read_failed <= rf;
        s_scan_start  <= ss;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_byte(d, rf, ss);
        bytes_sent++;
    endtask

    // Send the block in blk_kind/blk_serial, stopping after cut bytes
    task automatic send_block(input logic with_start, input int cut);
        int sent;
        sent = 0;
        for (int s = 0; s < SECTORS; s++) begin
            build_header(blk_kind[s], blk_serial[s]);
            for (int b = 0; b < HEADER_BYTES; b++) begin
                if (sent == cut)
                    return;
                send_byte(hdr_bytes[b], fail_byte == b, with_start && s == 0 && b == 0);
                sent++;
            end
        end
    endtask

    function automatic void fill_block(input hdr_kind_t kind, input logic [31:0] serial);
        for (int s = 0; s < SECTORS; s++) begin
            blk_kind[s]   = kind;
            blk_serial[s] = serial;
        end
    endfunction

    task automatic test_saved_block();
        fill_block(HDR_VALID, 32'd0);
        // max serial appears three times: the first one must win
        blk_serial = '{32'd5, 32'h7FFF_FFFF, 32'd3, 32'h7FFF_FFFF,
                       32'd0, 32'd1, 32'h7FFF_FFFF, 32'd2};
        send_block(1'b1, BLOCK_BYTES);
        // tie on a small serial, then a later larger one
        blk_serial = '{32'd9, 32'd9, 32'd4, 32'd9, 32'd0, 32'd12, 32'd12, 32'd1};
        send_block(1'b0, BLOCK_BYTES);
    endtask

    task automatic test_sector_classes();
        blk_kind   = '{HDR_VALID, HDR_NO_START, HDR_NO_END, HDR_BAD_CRC,
                       HDR_TOP_BIT, HDR_READ_FAIL, HDR_VALID, HDR_BLANK};
        // bad sectors carry serials too; the larger one after the corruption is ignored
        blk_serial = '{32'h10, 32'h1234_5678, 32'h7FFF_FFFF, 32'h55,
                       32'h7FFF_FFFF, 32'h2AAA_AAAA, 32'h7FFF_FFFF, 32'd0};
        send_block(1'b0, BLOCK_BYTES);
    endtask

    task automatic test_uniform_blocks();
        // run these blocks with no idling on either side
        steady = 1'b1;
        fill_block(HDR_BLANK, 32'd0);
        send_block(1'b0, BLOCK_BYTES);
        // all empty: status empty, newest fields stay zero
        fill_block(HDR_VALID, 32'd0);
        send_block(1'b0, BLOCK_BYTES);
        // one uninitialized sector among saves makes the block corrupt
        fill_block(HDR_VALID, 32'd7);
        blk_kind[2]   = HDR_GARBAGE;
        blk_serial[5] = 32'd20;
        send_block(1'b0, BLOCK_BYTES);
        steady = 1'b0;
    endtask

    task automatic test_scan_restart();
        for (int s = 0; s < SECTORS; s++) begin
            blk_kind[s]   = HDR_VALID;
            blk_serial[s] = pick_serial() & 32'h7FFF_FFFF;
        end
        // drop a partial sector, then a partial block, then run a full one
        send_block(1'b1, 45);
        send_block(1'b1, 130);
        send_block(1'b1, BLOCK_BYTES);
    endtask

    task automatic test_random_traffic();
        int  first_byte;
        int  flavor;
        int  cut;
        logic force_start;
        first_byte   = bytes_sent;
        force_start  = 1'b0;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            flavor = $urandom_range(0, 99);
            for (int s = 0; s < SECTORS; s++) begin
                blk_serial[s] = pick_serial();
                if (flavor < 55)
                    blk_kind[s] = HDR_VALID;
                else if (flavor < 65)
                    blk_kind[s] = $urandom_range(0, 1) ? HDR_BLANK : HDR_GARBAGE;
                else
                    blk_kind[s] = hdr_kind_t'($urandom_range(HDR_VALID, HDR_READ_FAIL));
            end
            cut = BLOCK_BYTES;
            if ($urandom_range(0, 99) < 8)
                cut = $urandom_range(1, BLOCK_BYTES - 1);
            send_block(force_start || $urandom_range(0, 1), cut);
            force_start = (cut != BLOCK_BYTES);
            // occasional burst of junk bytes with random flags
            if ($urandom_range(0, 99) < 5) begin
                repeat ($urandom_range(1, 40))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                              $urandom_range(0, 19) == 0);
                force_start = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        sector_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sector_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual index %0d class %0d",
                         $time, m_sector_index, m_sector_class);
            end else begin
                want = sector_reports.pop_front();
                check_field("sector_index", want.idx, m_sector_index);
                check_field("sector_class", want.cls, m_sector_class);
                check_field("sector_serial", want.serial, m_sector_serial);
                check_field("block_done", want.done, m_block_done);
                check_field("block_status", want.status, m_block_status);
                check_field("newest_sector", want.newest_idx, m_newest_sector);
                check_field("newest_serial", want.newest_serial, m_newest_serial);
                reports_checked++;
            end
        end
    end

    initial begin
        clear_block_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_saved_block();
        test_sector_classes();
        test_uniform_blocks();
        test_scan_restart();
        test_random_traffic();
        s_valid <= 1'b0;

        while (sector_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d header bytes, checked %0d of %0d sector reports", bytes_sent,
                 reports_checked, reports_predicted);
        $display("Blocks closed: %0d saved, %0d empty, %0d corrupt, %0d uninitialized",
                 block_status_count[CLASS_SAVED], block_status_count[CLASS_EMPTY],
                 block_status_count[CLASS_CORRUPT], block_status_count[CLASS_UNINIT]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
